// ===== hdl/first_fit_block_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared property wrappers for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define FFBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Default sizes, stream widths, status codes, request kinds and the run unit control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Default pool geometry
  localparam int FFBA_NUM_BLOCKS  = 32;
  localparam int FFBA_BLOCK_BYTES = 64;

  // Stream widths (whole bytes)
  localparam int FFBA_IN_W  = 24;
  localparam int FFBA_OUT_W = 56;

  // Result status codes
  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NOT_ENOUGH = 3'd2;
  localparam logic [2:0] ST_NO_HANDLE  = 3'd3;
  localparam logic [2:0] ST_NO_RUN     = 3'd4;
  localparam logic [2:0] ST_FREED      = 3'd5;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd6;

  // Request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Control from the sequencer to the run unit
  typedef struct packed {
    logic clear;     // start a new search
    logic step;      // take one block
    logic blk_free;  // the block being taken is free
  } ffba_run_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ffba_run_unit.sv =====
// ----------------------------------------------------------------------------
// First-fit run unit
// Tracks the current run of free blocks, one block per step, and flags
// when the run covers the requested byte size.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_run_unit #(
  parameter int NUM_BLOCKS  = ffba_pkg::FFBA_NUM_BLOCKS,
  parameter int BLOCK_BYTES = ffba_pkg::FFBA_BLOCK_BYTES
) (
  input  wire logic                              clk,
  input  wire ffba_pkg::ffba_run_ctrl_t          ctrl,
  input  wire logic [$clog2(NUM_BLOCKS)-1:0]     idx,
  input  wire logic [15:0]                       size,
  output logic                                   hit,
  output logic [$clog2(NUM_BLOCKS)-1:0]          run_start,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]        run_len
);

  import ffba_pkg::*;

  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int BYTE_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);

  logic [BYTE_W-1:0] run_bytes;

  // Run covers the request once its bytes reach the size
  assign hit = (32'(run_bytes) >= 32'(size));

  // Length and bytes grow together, a busy block restarts the run
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      run_len   <= '0;
      run_bytes <= '0;
      run_start <= '0;
    end else if (ctrl.step) begin
      if (!ctrl.blk_free) begin
        run_len   <= '0;
        run_bytes <= '0;
      end else begin
        if (run_len == '0) begin
          run_start <= idx;
        end
        run_len   <= run_len + CNT_W'(1);
        run_bytes <= run_bytes + BYTE_W'(BLOCK_BYTES);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator_core.sv =====
// Allocate: accept, S_MUL, S_CHK, then the run scan, which visits one block and
//   one handle per cycle, then S_MARK and S_DONE; early rejects go from S_CHK to S_DONE.
// Free: handle table read at accept, then release in S_FREE, then the result in S_DONE.
// One request at a time: s_axis_tready is high only while the sequencer is idle.
// Reset (rst, synchronous) frees every block and handle and clears the totals;
//   the handle table is not cleared and is read only for busy handles.
// ----------------------------------------------------------------------------
// First-fit block allocator core
// Bookkeeping for a pool of equal blocks: first-fit allocate and free by handle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int NUM_BLOCKS  = ffba_pkg::FFBA_NUM_BLOCKS,
  parameter int BLOCK_BYTES = ffba_pkg::FFBA_BLOCK_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // size [15:0], handle [20:16], zero pad [23:21]
  input  wire logic [ffba_pkg::FFBA_IN_W-1:0] s_axis_tdata,
  // op [0]
  input  wire logic [0:0]                     s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status [2:0], granted_handle [7:3], start_block [12:8], block_count [18:13],
  // byte_offset [29:19], granted_bytes [41:30], used_blocks [47:42],
  // used_handles [53:48], zero pad [55:54]
  output logic [ffba_pkg::FFBA_OUT_W-1:0]     m_axis_tdata
);

  import ffba_pkg::*;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int BYTE_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam int POOL   = NUM_BLOCKS * BLOCK_BYTES;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]            state;
  logic [NUM_BLOCKS-1:0] block_busy;
  logic [NUM_BLOCKS-1:0] handle_busy;
  logic [CNT_W-1:0]      busy_block_total;
  logic [CNT_W-1:0]      busy_handle_total;

  // Latched request
  logic [15:0]           req_size;
  logic [4:0]            req_handle;

  // Scan bookkeeping
  logic [CNT_W-1:0]      scan_i;
  logic                  hfound;
  logic [BLK_W-1:0]      hidx;
  logic [BYTE_W-1:0]     free_bytes;

  // Result held for formatting
  logic [2:0]            res_status;
  logic [4:0]            res_handle;
  logic [BLK_W-1:0]      res_start;
  logic [CNT_W-1:0]      res_count;

  // Handle table: first block and run length
  logic [BLK_W+CNT_W-1:0] hmem [NUM_BLOCKS];
  logic [BLK_W+CNT_W-1:0] hmem_rd;
  logic [BLK_W-1:0]       mem_first;
  logic [CNT_W-1:0]       mem_len;

  // Input decode
  logic                  accept;
  logic [31:0]           in_h_ext;
  logic [BLK_W-1:0]      in_hidx;
  logic [31:0]           req_h_ext;
  logic [BLK_W-1:0]      req_hidx;
  logic                  req_h_ok;
  logic [BLK_W-1:0]      scan_idx;

  // Run unit
  ffba_run_ctrl_t        run_ctrl;
  logic                  run_hit;
  logic [BLK_W-1:0]      run_start;
  logic [CNT_W-1:0]      run_len;

  // Range mask for mark and release
  logic [31:0]           rng_lo;
  logic [31:0]           rng_hi;
  logic [NUM_BLOCKS-1:0] rng_mask;

  // Output formatting
  logic [31:0]           fmt_start;
  logic [31:0]           fmt_cnt;
  logic [31:0]           fmt_hidx;
  logic [31:0]           fmt_off;
  logic [31:0]           fmt_bytes;
  logic [31:0]           fmt_ublk;
  logic [31:0]           fmt_uhdl;
  logic                  out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_h_ext  = 32'(s_axis_tdata[20:16]);
  assign in_hidx   = in_h_ext[BLK_W-1:0];
  assign req_h_ext = 32'(req_handle);
  assign req_hidx  = req_h_ext[BLK_W-1:0];
  assign req_h_ok  = (req_h_ext < 32'(NUM_BLOCKS));
  assign scan_idx  = scan_i[BLK_W-1:0];
  assign fmt_hidx  = 32'(hidx);

  assign mem_first = hmem_rd[BLK_W+CNT_W-1:CNT_W];
  assign mem_len   = hmem_rd[CNT_W-1:0];

  // Run unit control
  always_comb begin
    run_ctrl.clear    = (state == S_CHK);
    run_ctrl.step     = (state == S_SCAN) && !run_hit && (scan_i != CNT_W'(NUM_BLOCKS));
    run_ctrl.blk_free = !block_busy[scan_idx];
  end

  ffba_run_unit #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_run_unit (
    .clk       (clk),
    .ctrl      (run_ctrl),
    .idx       (scan_idx),
    .size      (req_size),
    .hit       (run_hit),
    .run_start (run_start),
    .run_len   (run_len)
  );

  // Block range [lo, hi] of the run being marked or released
  always_comb begin
    if (state == S_FREE) begin
      rng_lo = 32'(mem_first);
      rng_hi = 32'(mem_first) + 32'(mem_len) - 32'd1;
    end else begin
      rng_lo = 32'(run_start);
      rng_hi = 32'(run_start) + 32'(run_len) - 32'd1;
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      rng_mask[b] = (32'(b) >= rng_lo) && (32'(b) <= rng_hi);
    end
  end

  // Handle table write on grant, registered read at accept
  always_ff @(posedge clk) begin
    if (state == S_MARK) begin
      hmem[hidx] <= {run_start, run_len};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hmem_rd <= hmem[in_hidx];
    end
  end

  // Result formatting products
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign fmt_start = 32'(res_start);
  assign fmt_cnt   = 32'(res_count);
  assign fmt_off   = 32'(res_start) * 32'(BLOCK_BYTES);
  assign fmt_bytes = 32'(res_count) * 32'(BLOCK_BYTES);
  assign fmt_ublk  = 32'(busy_block_total);
  assign fmt_uhdl  = 32'(busy_handle_total);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      block_busy        <= '0;
      handle_busy       <= '0;
      busy_block_total  <= '0;
      busy_handle_total <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      // a new result in S_DONE takes over the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_size   <= s_axis_tdata[15:0];
            req_handle <= s_axis_tdata[20:16];
            state      <= (s_axis_tuser[0] == OP_FREE) ? S_FREE : S_MUL;
          end
        end
        S_MUL: begin
          free_bytes <= BYTE_W'((32'(NUM_BLOCKS) - 32'(busy_block_total))
                                * 32'(BLOCK_BYTES));
          state      <= S_CHK;
        end
        S_CHK: begin
          res_handle <= '0;
          res_start  <= '0;
          res_count  <= '0;
          scan_i     <= '0;
          hfound     <= 1'b0;
          if (req_size == 16'd0 || 32'(req_size) > 32'(POOL)) begin
            res_status <= ST_BAD_SIZE;
            state      <= S_DONE;
          end else if (32'(req_size) > 32'(free_bytes)) begin
            res_status <= ST_NOT_ENOUGH;
            state      <= S_DONE;
          end else if (busy_handle_total >= CNT_W'(NUM_BLOCKS)) begin
            res_status <= ST_NO_HANDLE;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (run_hit && hfound) begin
            state <= S_MARK;
          end else if (scan_i == CNT_W'(NUM_BLOCKS)) begin
            // a free handle always exists here, so only the run can be missing
            res_status <= ST_NO_RUN;
            state      <= S_DONE;
          end else begin
            if (!hfound && !handle_busy[scan_idx]) begin
              hfound <= 1'b1;
              hidx   <= scan_idx;
            end
            scan_i <= scan_i + CNT_W'(1);
          end
        end
        S_MARK: begin
          block_busy        <= block_busy | rng_mask;
          handle_busy[hidx] <= 1'b1;
          busy_block_total  <= busy_block_total + run_len;
          busy_handle_total <= busy_handle_total + CNT_W'(1);
          res_status        <= ST_GRANTED;
          res_handle        <= fmt_hidx[4:0];
          res_start         <= run_start;
          res_count         <= run_len;
          state             <= S_DONE;
        end
        S_FREE: begin
          res_handle <= req_handle;
          if (req_h_ok && handle_busy[req_hidx]) begin
            block_busy            <= block_busy & ~rng_mask;
            handle_busy[req_hidx] <= 1'b0;
            busy_block_total      <= busy_block_total - mem_len;
            busy_handle_total     <= busy_handle_total - CNT_W'(1);
            res_status            <= ST_FREED;
            res_start             <= mem_first;
            res_count             <= mem_len;
          end else begin
            res_status <= ST_BAD_HANDLE;
            res_start  <= '0;
            res_count  <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to be free
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, fmt_uhdl[5:0], fmt_ublk[5:0], fmt_bytes[11:0],
                              fmt_off[10:0], fmt_cnt[5:0],
                              fmt_start[4:0], res_handle, res_status};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator checker
// Port-level assertions on the allocator streams, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_core_defines.svh"

module ffba_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [ffba_pkg::FFBA_OUT_W-1:0] m_axis_tdata
);

  import ffba_pkg::*;

  logic [2:0]  status;
  logic [41:8] run_fields;
  logic        rejected;

  assign status     = m_axis_tdata[2:0];
  assign run_fields = m_axis_tdata[41:8];
  assign rejected   = (status == ST_BAD_SIZE) || (status == ST_NOT_ENOUGH) ||
                      (status == ST_NO_HANDLE) || (status == ST_NO_RUN) ||
                      (status == ST_BAD_HANDLE);

  // A stalled result holds
  `FFBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // One request at a time: ready drops after each transaction
  `FFBA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in flight")

  // Rejected requests carry no run
  `FFBA_ASSERT_SAME(a_reject_zero, m_axis_tvalid && rejected, run_fields == '0, "rejected result carries a run")

  // Status is always a defined code
  `FFBA_ASSERT_SAME(a_status_code, m_axis_tvalid, status != 3'd7, "undefined status code")

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

`default_nettype wire
